FILE: design/kpd_pkg.sv
// kpd_pkg: shared types, codes and constants of the keyboard packet deframer
// no dependencies; used by every module of the block

package kpd_pkg;

    // buffer geometry
    localparam int unsigned SLOT_COUNT    = 8;
    localparam int unsigned VIEW_COUNT    = 7;
    localparam int unsigned QUEUE_DEPTH   = 2;

    typedef logic [7:0]                  t_byte;
    typedef logic [2:0]                  t_slot;
    typedef logic [2:0]                  t_count;
    typedef t_byte [SLOT_COUNT-1:0]      t_snap;
    typedef t_byte [VIEW_COUNT-1:0]      t_view;

    // header bytes
    localparam t_byte HDR_KEY       = 8'hF5;
    localparam t_byte HDR_STATUS    = 8'hF6;
    localparam t_byte HDR_ABS_MOUSE = 8'hF7;
    localparam t_byte HDR_REL_FIRST = 8'hF8;
    localparam t_byte HDR_REL_LAST  = 8'hFB;
    localparam t_byte HDR_CLOCK     = 8'hFC;
    localparam t_byte HDR_JOY_BOTH  = 8'hFD;
    localparam t_byte HDR_JOY_ZERO  = 8'hFE;
    localparam t_byte HDR_JOY_ONE   = 8'hFF;

    // record kinds
    typedef enum logic [2:0] {
        KIND_KEY       = 3'd0,
        KIND_STATUS    = 3'd1,
        KIND_ABS_MOUSE = 3'd2,
        KIND_REL_MOUSE = 3'd3,
        KIND_CLOCK     = 3'd4,
        KIND_JOYSTICK  = 3'd5
    } t_kind;

    // number of data bytes that follow a header
    function automatic t_count f_pkt_len(input t_byte hdr);
        t_count len;
        case (hdr)
            HDR_STATUS:                len = 3'd7;
            HDR_ABS_MOUSE:             len = 3'd5;
            HDR_CLOCK:                 len = 3'd6;
            HDR_JOY_BOTH:              len = 3'd2;
            HDR_JOY_ZERO, HDR_JOY_ONE: len = 3'd1;
            default: begin
                // relative mouse headers carry two bytes
                if (hdr inside {[HDR_REL_FIRST:HDR_REL_LAST]}) len = 3'd2;
                else len = 3'd0;
            end
        endcase
        return len;
    endfunction

endpackage

FILE: design/kpd_front.sv
// kpd_front: takes received bytes, tracks the packet in progress and the slot buffer
// depends on kpd_pkg; hands a buffer snapshot to the queue when a record is due

module kpd_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  kpd_pkg::t_byte i_rx_byte,
    input  logic           i_full,
    output logic           o_push,
    output kpd_pkg::t_snap o_snap
);

    logic            r_recv,  n_recv;
    kpd_pkg::t_count r_left,  n_left;
    kpd_pkg::t_slot  r_slot,  n_slot;
    kpd_pkg::t_snap  r_store, n_store;
    logic            accept;
    logic            push;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;

    // per-byte update of the packet state and slot buffer
    always_comb begin
        n_recv  = r_recv;
        n_left  = r_left;
        n_slot  = r_slot;
        n_store = r_store;
        push    = 1'b0;
        if (accept) begin
            if (r_recv) begin
                n_store[r_slot] = i_rx_byte;
                n_left          = r_left - 3'd1;
                if (n_left == 3'd0) begin
                    n_recv = 1'b0;
                    push   = 1'b1;
                end else begin
                    n_slot = r_slot + 3'd1;
                end
            end else if (i_rx_byte >= kpd_pkg::HDR_STATUS) begin
                n_left     = kpd_pkg::f_pkt_len(i_rx_byte);
                n_store[0] = i_rx_byte;
                n_recv     = 1'b1;
                n_slot     = 3'd1;
            end else begin
                n_store[0] = kpd_pkg::HDR_KEY;
                n_store[1] = i_rx_byte;
                push       = 1'b1;
            end
            // joystick one packet: move its byte to slot 2, kept in the buffer
            if (push && !(n_store[0] inside {[kpd_pkg::HDR_KEY:kpd_pkg::HDR_JOY_ZERO]})) begin
                n_store[2] = n_store[1];
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recv  <= 1'b0;
            r_left  <= '0;
            r_slot  <= '0;
            r_store <= '0;
        end else begin
            r_recv  <= n_recv;
            r_left  <= n_left;
            r_slot  <= n_slot;
            r_store <= n_store;
        end
    end

    assign o_push = push;
    assign o_snap = n_store;

    // a packet in progress always has bytes to go and a data slot
    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_recv |-> (r_left != 3'd0 && r_slot != 3'd0))
        else $error("packet in progress with empty count or header slot");

    // a record is only raised for an accepted byte
    a_push_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> accept)
        else $error("record raised without an accepted byte");

endmodule

FILE: design/kpd_queue.sv
// kpd_queue: short queue of buffer snapshots between the front and back parts
// depends on kpd_pkg for the snapshot type

module kpd_queue #(
    parameter int unsigned DEPTH = kpd_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  kpd_pkg::t_snap i_data,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_pop,
    output kpd_pkg::t_snap o_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    kpd_pkg::t_snap     r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr, r_rd;
    logic [CNT_W-1:0]   r_cnt;
    logic               push, pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign push    = i_push && !o_full;
    assign pop     = i_pop && o_valid;
    assign o_data  = r_mem[r_rd];

    // snapshot storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            r_cnt <= r_cnt + CNT_W'(push) - CNT_W'(pop);
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("snapshot pushed into full queue");

endmodule

FILE: design/kpd_back.sv
// kpd_back: turns a buffer snapshot into a record and holds it in the output register
// depends on kpd_pkg for header codes, kinds and types

module kpd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    output logic           o_q_pop,
    input  kpd_pkg::t_snap i_snap,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [2:0]     o_event_kind,
    output kpd_pkg::t_byte o_arg_byte,
    output logic [2:0]     o_view_len,
    output kpd_pkg::t_view o_view
);

    logic            r_valid;
    kpd_pkg::t_kind  r_kind,  n_kind;
    kpd_pkg::t_byte  r_arg,   n_arg;
    logic [2:0]      r_len,   n_len;
    kpd_pkg::t_view  r_view,  n_view;
    logic            load;

    assign load    = i_q_valid && (!r_valid || i_ready);
    assign o_q_pop = load;

    // record formatting by header byte
    always_comb begin
        n_kind = kpd_pkg::KIND_JOYSTICK;
        n_arg  = '0;
        n_len  = 3'd0;
        n_view = '0;
        case (i_snap[0])
            kpd_pkg::HDR_KEY: begin
                n_kind = kpd_pkg::KIND_KEY;
                n_arg  = i_snap[1];
            end
            kpd_pkg::HDR_STATUS: begin
                n_kind = kpd_pkg::KIND_STATUS;
                n_len  = 3'd7;
                n_view = i_snap[7:1];
            end
            kpd_pkg::HDR_ABS_MOUSE: begin
                n_kind      = kpd_pkg::KIND_ABS_MOUSE;
                n_len       = 3'd5;
                n_view[4:0] = i_snap[5:1];
            end
            kpd_pkg::HDR_CLOCK: begin
                n_kind      = kpd_pkg::KIND_CLOCK;
                n_len       = 3'd6;
                n_view[5:0] = i_snap[6:1];
            end
            kpd_pkg::HDR_JOY_BOTH: begin
                n_arg       = i_snap[2];
                n_len       = 3'd2;
                n_view[1:0] = i_snap[2:1];
            end
            kpd_pkg::HDR_JOY_ZERO: begin
                n_arg       = i_snap[1];
                n_len       = 3'd3;
                n_view[2:0] = i_snap[2:0];
            end
            default: begin
                // relative mouse range, else joystick one (slot 2 already fixed up)
                if (i_snap[0] inside {[kpd_pkg::HDR_REL_FIRST:kpd_pkg::HDR_REL_LAST]}) begin
                    n_kind = kpd_pkg::KIND_REL_MOUSE;
                end else begin
                    n_arg  = i_snap[2];
                end
                n_len       = 3'd3;
                n_view[2:0] = i_snap[2:0];
            end
        endcase
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind <= n_kind;
            r_arg  <= n_arg;
            r_len  <= n_len;
            r_view <= n_view;
        end
    end

    assign o_valid      = r_valid;
    assign o_event_kind = r_kind;
    assign o_arg_byte   = r_arg;
    assign o_view_len   = r_len;
    assign o_view       = r_view;

    // a held record is never replaced before it is taken
    a_no_clobber: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_ready) |-> !load)
        else $error("output record overwritten while stalled");

endmodule

FILE: design/keyboard_packet_deframer_core.sv
// keyboard_packet_deframer_core: top level of the keyboard packet deframer
// depends on kpd_pkg, kpd_front, kpd_queue and kpd_back

// Takes one keyboard-controller byte per request and gives one record per key
// event or completed packet. A byte can be taken in every cycle: the front part
// updates the packet state and slot buffer in the accepting cycle and drops a
// buffer snapshot into a QUEUE_DEPTH-entry queue; the back part formats the head
// snapshot into the output register when that register is empty or its record is
// being taken, so a record waits first in the queue and then in the output
// register. o_ready falls only while the queue is full, which happens when the
// output side stalls.

module keyboard_packet_deframer_core #(
    parameter int unsigned QUEUE_DEPTH = kpd_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [2:0] o_event_kind,
    output logic [7:0] o_arg_byte,
    output logic [2:0] o_view_len,
    output logic [7:0] o_view_b0,
    output logic [7:0] o_view_b1,
    output logic [7:0] o_view_b2,
    output logic [7:0] o_view_b3,
    output logic [7:0] o_view_b4,
    output logic [7:0] o_view_b5,
    output logic [7:0] o_view_b6
);

    logic           q_full, q_push, q_valid, q_pop;
    kpd_pkg::t_snap push_snap, head_snap;
    kpd_pkg::t_view view;

    // front: byte intake and packet tracking
    kpd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_rx_byte (i_rx_byte),
        .i_full    (q_full),
        .o_push    (q_push),
        .o_snap    (push_snap)
    );

    // snapshot queue
    kpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (push_snap),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (head_snap)
    );

    // back: record formatting and output register
    kpd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .o_q_pop      (q_pop),
        .i_snap       (head_snap),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_event_kind (o_event_kind),
        .o_arg_byte   (o_arg_byte),
        .o_view_len   (o_view_len),
        .o_view       (view)
    );

    assign o_view_b0 = view[0];
    assign o_view_b1 = view[1];
    assign o_view_b2 = view[2];
    assign o_view_b3 = view[3];
    assign o_view_b4 = view[4];
    assign o_view_b5 = view[5];
    assign o_view_b6 = view[6];

endmodule
